// File: hw/rtl/bfq_pkg.sv
// ----------------------------------------------------------------------------
// bfq_pkg
// shared constants, codes and types of the batch fifo queue
// ----------------------------------------------------------------------------
package bfq_pkg;

   localparam int DEPTH        = 64;
   localparam int ELEMENT_BITS = 32;

   localparam int ELEMENT_PORT_BITS = 32;
   localparam int COUNT_BITS        = 7;
   localparam int ELEM_W  = (ELEMENT_BITS < ELEMENT_PORT_BITS) ? ELEMENT_BITS
                                                               : ELEMENT_PORT_BITS;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam int QDEPTH  = 4;
   localparam int QIDX_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      action_type              action;
      logic [ELEM_W-1:0]       element;
      logic [COUNT_BITS-1:0]   count;
      logic                    last;
      logic                    discard;
   } cmd_type;

   typedef struct packed {
      status_type              status;
      logic                    last;
      logic [CNT_W-1:0]        occ;
      logic                    use_ram;
   } result_type;

endpackage

// File: hw/rtl/bfq_ram.sv
// ----------------------------------------------------------------------------
// bfq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/bfq_front.sv
// ----------------------------------------------------------------------------
// bfq_front
// accepts request items, classifies them into commands and queues them
// ----------------------------------------------------------------------------
module bfq_front
   import bfq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [1:0]               req_tuser,
   input  logic                     req_tlast,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output cmd_type                  cmd
);

   cmd_type           queue_ff [QDEPTH];
   logic [QIDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QIDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_type           new_cmd;
   logic              push, pop;

   always_comb begin
      new_cmd.action  = action_type'(req_tuser);
      new_cmd.element = ELEM_W'(req_tdata[ELEMENT_PORT_BITS-1:0]);
      new_cmd.count   = req_tdata[ELEMENT_PORT_BITS +: COUNT_BITS];
      new_cmd.last    = req_tlast;
      new_cmd.discard = req_tdata[ELEMENT_PORT_BITS + COUNT_BITS];
   end

   assign req_tready = (count_ff != QCNT_W'(QDEPTH));
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// File: hw/rtl/bfq_back.sv
// ----------------------------------------------------------------------------
// bfq_back
// carries out queued commands on the ring buffer and delivers results
// ----------------------------------------------------------------------------
module bfq_back
   import bfq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  cmd_type                  cmd,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tlast
);

   typedef enum logic {
      S_IDLE,
      S_POP
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic                   open_ff, open_in;
   logic                   accepted_ff, accepted_in;
   logic [CNT_W-1:0]       written_ff, written_in;
   logic [CNT_W-1:0]       target_ff, target_in;
   logic [CNT_W-1:0]       remain_ff, remain_in;
   logic                   discard_ff, discard_in;

   logic                   pend_valid_ff, pend_valid_in;
   result_type             pend_ff, pend_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;
   logic [ELEM_W-1:0]      out_elem_ff, out_elem_in;

   logic                   slot_ok, pend_move;
   logic                   ram_we, ram_re;
   logic [IDX_W-1:0]       ram_waddr, ram_raddr;
   logic [ELEM_W-1:0]      ram_rdata;

   logic                   b_acc;
   logic [CNT_W-1:0]       b_target, b_written, b_written_n, free_cnt;

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return IDX_W'(sum);
   endfunction

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   bfq_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd.element),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign pend_move = pend_valid_ff && (!out_valid_ff || rsp_tready);
   assign slot_ok   = !pend_valid_ff || pend_move;

   // push batch bookkeeping
   always_comb begin
      free_cnt    = CNT_W'(DEPTH) - fill_ff;
      b_acc       = open_ff ? accepted_ff
                            : (cmd.count <= COUNT_BITS'(DEPTH)) &&
                              (COUNT_BITS'(free_cnt) >= cmd.count);
      b_target    = open_ff ? target_ff : CNT_W'(cmd.count);
      b_written   = open_ff ? written_ff : '0;
      b_written_n = (b_acc && (b_written < b_target)) ? b_written + 1'b1 : b_written;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      open_in       = open_ff;
      accepted_in   = accepted_ff;
      written_in    = written_ff;
      target_in     = target_ff;
      remain_in     = remain_ff;
      discard_in    = discard_ff;
      cmd_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = wrap_add(tail_ff, b_written);
      ram_re        = 1'b0;
      ram_raddr     = head_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;

      if (pend_move) begin
         pend_valid_in = 1'b0;
      end

      case (state_ff)
         S_POP: begin
            if (slot_ok) begin
               ram_re          = !discard_ff;
               head_in         = next_idx(head_ff);
               remain_in       = remain_ff - 1'b1;
               pend_valid_in   = 1'b1;
               pend_in.status  = STATUS_OK;
               pend_in.last    = (remain_ff == CNT_W'(1));
               pend_in.occ     = fill_ff;
               pend_in.use_ram = !discard_ff;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.action)
                  ACT_PUSH: begin
                     if (!cmd.last || slot_ok) begin
                        cmd_ready = 1'b1;
                        ram_we    = b_acc && (b_written < b_target);
                        if (!cmd.last) begin
                           open_in     = 1'b1;
                           accepted_in = b_acc;
                           target_in   = b_target;
                           written_in  = b_written_n;
                        end else begin
                           open_in         = 1'b0;
                           accepted_in     = 1'b0;
                           target_in       = '0;
                           written_in      = '0;
                           pend_valid_in   = 1'b1;
                           pend_in.last    = 1'b1;
                           pend_in.use_ram = 1'b0;
                           if (b_acc) begin
                              tail_in        = wrap_add(tail_ff, b_written_n);
                              fill_in        = fill_ff + b_written_n;
                              pend_in.status = STATUS_OK;
                              pend_in.occ    = fill_ff + b_written_n;
                           end else begin
                              pend_in.status = STATUS_FULL;
                              pend_in.occ    = fill_ff;
                           end
                        end
                     end
                  end
                  ACT_POP: begin
                     if (slot_ok) begin
                        cmd_ready       = 1'b1;
                        pend_valid_in   = 1'b1;
                        pend_in.status  = STATUS_OK;
                        pend_in.last    = 1'b1;
                        pend_in.occ     = fill_ff;
                        pend_in.use_ram = 1'b0;
                        if (cmd.count == '0) begin
                           pend_in.status = STATUS_OK;
                        end else if ((cmd.count > COUNT_BITS'(DEPTH)) ||
                                     (cmd.count > COUNT_BITS'(fill_ff))) begin
                           pend_in.status = STATUS_EMPTY;
                        end else begin
                           fill_in         = fill_ff - CNT_W'(cmd.count);
                           ram_re          = !cmd.discard;
                           head_in         = next_idx(head_ff);
                           pend_in.occ     = fill_ff - CNT_W'(cmd.count);
                           pend_in.use_ram = !cmd.discard;
                           pend_in.last    = (cmd.count == COUNT_BITS'(1));
                           if (cmd.count != COUNT_BITS'(1)) begin
                              state_in   = S_POP;
                              remain_in  = CNT_W'(cmd.count) - 1'b1;
                              discard_in = cmd.discard;
                           end
                        end
                     end
                  end
                  ACT_CLEAR: begin
                     if (slot_ok) begin
                        cmd_ready       = 1'b1;
                        head_in         = '0;
                        tail_in         = '0;
                        fill_in         = '0;
                        open_in         = 1'b0;
                        accepted_in     = 1'b0;
                        written_in      = '0;
                        target_in       = '0;
                        pend_valid_in   = 1'b1;
                        pend_in.status  = STATUS_OK;
                        pend_in.last    = 1'b1;
                        pend_in.occ     = '0;
                        pend_in.use_ram = 1'b0;
                     end
                  end
                  ACT_QUERY: begin
                     if (slot_ok) begin
                        cmd_ready       = 1'b1;
                        pend_valid_in   = 1'b1;
                        pend_in.status  = STATUS_OK;
                        pend_in.last    = 1'b1;
                        pend_in.occ     = fill_ff;
                        pend_in.use_ram = 1'b0;
                     end
                  end
                  default: begin
                     cmd_ready = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_elem_in  = out_elem_ff;
      if (pend_move) begin
         out_valid_in = 1'b1;
         out_in       = pend_ff;
         out_elem_in  = pend_ff.use_ram ? ram_rdata : '0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         open_ff       <= 1'b0;
         accepted_ff   <= 1'b0;
         written_ff    <= '0;
         target_ff     <= '0;
         remain_ff     <= '0;
         discard_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         open_ff       <= open_in;
         accepted_ff   <= accepted_in;
         written_ff    <= written_in;
         target_ff     <= target_in;
         remain_ff     <= remain_in;
         discard_ff    <= discard_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_elem_ff <= out_elem_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = RSP_DATA_BITS'({COUNT_BITS'(out_ff.occ),
                                       ELEMENT_PORT_BITS'(out_elem_ff)});

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_pop_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (remain_ff != '0))
      else $error("pop burst with nothing left");

   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !pend_move) |=> (pend_valid_ff && $stable(pend_ff)))
      else $error("pending result lost");

   a_batch_written: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (written_ff <= target_ff))
      else $error("batch wrote past its count");

   a_no_cmd_in_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> !cmd_ready)
      else $error("command taken during pop burst");

endmodule

// File: hw/rtl/batch_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// batch_fifo_queue_top
// ring-buffer fifo with all-or-nothing batch push and batch pop
// ----------------------------------------------------------------------------
// path: each item waits in the command queue; its result passes the pending register, then the output register
// throughput: one item per cycle when nothing stalls; a pop of n elements holds the back end
// until its n results are issued, and a 4-entry command queue keeps taking items meanwhile
// reset: pointers, counts, open batch and queues cleared; element ram not cleared
// ----------------------------------------------------------------------------
module batch_fifo_queue_top
   import bfq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // element, batch_count, discard
   input  logic [1:0]               req_tuser,  // action
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // out_element, occupancy
   output logic [1:0]               rsp_tuser,  // status
   output logic                     rsp_tlast
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   bfq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   bfq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: test/batch_fifo_queue_top_tb.sv
// ----------------------------------------------------------------------------
// batch_fifo_queue_top_tb
// self-checking bench for the ring-buffer fifo with batch push and batch pop
// ----------------------------------------------------------------------------
// a directed run covers the corner cases of batch push and pop, then random
// batches, pops, clears and queries follow; a shadow fifo predicts every
// result and the monitor compares each one in order, with random idle bursts
// on both channels
// ----------------------------------------------------------------------------
module batch_fifo_queue_top_tb;
   import bfq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int CALM_TAIL = 40;

   typedef struct {
      action_type           action;
      logic [31:0]          element;
      logic [COUNT_BITS-1:0] count;
      logic                 last;
      logic                 discard;
   } fifo_op_type;

   typedef struct {
      status_type           status;
      logic [31:0]          element;
      logic                 last;
      logic [COUNT_BITS-1:0] occ;
   } fifo_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;  // element, batch_count, discard
   logic [1:0]               req_tuser = '0;  // action
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;      // out_element, occupancy
   logic [1:0]               rsp_tuser;      // status
   logic                     rsp_tlast;

   fifo_op_type     op_backlog[$];
   fifo_result_type due_results[$];
   fifo_op_type     op_on_bus;
   int              idle_left = 0;
   int              stall_left = 0;
   int              error_count = 0;

   // shadow copy of the fifo
   logic [31:0] shadow_slots [DEPTH];
   int          shadow_head = 0;
   int          shadow_tail = 0;
   int          shadow_fill = 0;
   bit          shadow_open = 1'b0;
   bit          shadow_accepted = 1'b0;
   int          shadow_written = 0;
   int          shadow_target = 0;

   batch_fifo_queue_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic bit calm_phase();
      return op_backlog.size() < CALM_TAIL;
   endfunction

   function automatic void add_result(status_type status, logic [31:0] element, logic last);
      fifo_result_type res;
      res.status  = status;
      res.element = element;
      res.last    = last;
      res.occ     = COUNT_BITS'(shadow_fill);
      due_results.push_back(res);
   endfunction

   function automatic void shadow_fifo_step(fifo_op_type op);
      logic [31:0] value;
      status_type  status;
      int          n;
      value = '0;
      value[ELEM_W-1:0] = op.element[ELEM_W-1:0];
      n = int'(op.count);
      case (op.action)
         ACT_PUSH: begin
            if (!shadow_open) begin
               shadow_open     = 1'b1;
               shadow_written  = 0;
               shadow_target   = n;
               shadow_accepted = (n <= DEPTH) && (DEPTH - shadow_fill >= n);
            end
            if (shadow_accepted && shadow_written < shadow_target) begin
               shadow_slots[(shadow_tail + shadow_written) % DEPTH] = value;
               shadow_written++;
            end
            if (op.last) begin
               status = STATUS_FULL;
               if (shadow_accepted) begin
                  shadow_tail = (shadow_tail + shadow_written) % DEPTH;
                  shadow_fill += shadow_written;
                  status = STATUS_OK;
               end
               shadow_open     = 1'b0;
               shadow_accepted = 1'b0;
               shadow_written  = 0;
               shadow_target   = 0;
               add_result(status, '0, 1'b1);
            end
         end
         ACT_POP: begin
            if (n == 0) begin
               add_result(STATUS_OK, '0, 1'b1);
            end else if (n > DEPTH || n > shadow_fill) begin
               add_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               shadow_fill -= n;
               for (int i = 0; i < n; i++) begin
                  add_result(STATUS_OK, op.discard ? 32'd0 : shadow_slots[shadow_head],
                             (i + 1 == n));
                  shadow_head = (shadow_head + 1) % DEPTH;
               end
            end
         end
         ACT_CLEAR: begin
            shadow_head     = 0;
            shadow_tail     = 0;
            shadow_fill     = 0;
            shadow_open     = 1'b0;
            shadow_accepted = 1'b0;
            shadow_written  = 0;
            shadow_target   = 0;
            add_result(STATUS_OK, '0, 1'b1);
         end
         default: begin
            add_result(STATUS_OK, '0, 1'b1);
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            shadow_fifo_step(op_on_bus);
         end
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_tvalid <= 1'b0;
            end else if (op_backlog.size() > 0) begin
               op_on_bus = op_backlog.pop_front();
               req_tdata  <= {op_on_bus.discard, op_on_bus.count, op_on_bus.element};
               req_tuser  <= op_on_bus.action;
               req_tlast  <= op_on_bus.last;
               req_tvalid <= 1'b1;
               if (!calm_phase() && $urandom_range(0, 7) == 0) begin
                  idle_left = $urandom_range(1, 14);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fifo_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected item: status %0d element %h last %0d occupancy %0d",
                     $time, rsp_tuser, rsp_tdata[31:0], rsp_tlast, rsp_tdata[38:32]);
            error_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[31:0] !== want.element) begin
               $display("%0t: out_element mismatch: expected %h, actual %h",
                        $time, want.element, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: run_last mismatch: expected %0d, actual %0d",
                        $time, want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[38:32] !== want.occ) begin
               $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                        $time, want.occ, rsp_tdata[38:32]);
               error_count++;
            end
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm_phase() && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void add_op(action_type action, logic [31:0] element, int count,
                                  logic last, logic discard);
      fifo_op_type op;
      op.action  = action;
      op.element = element;
      op.count   = COUNT_BITS'(count);
      op.last    = last;
      op.discard = discard;
      op_backlog.push_back(op);
   endfunction

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int  r;
      int  c;
      int  n;
      int  k;
      int  track_fill;
      bit  fits;

      // directed corners
      add_op(ACT_QUERY, $urandom, 0, 1'b0, 1'b1);
      add_op(ACT_POP, $urandom, 1, 1'b1, 1'b0);
      add_op(ACT_POP, $urandom, 0, 1'b0, 1'b0);
      add_op(ACT_PUSH, 32'h0000_0000, 3, 1'b0, 1'b0);
      add_op(ACT_PUSH, 32'hFFFF_FFFF, 0, 1'b0, 1'b1);
      add_op(ACT_PUSH, 32'hA5A5_A5A5, 64, 1'b1, 1'b0);
      add_op(ACT_PUSH, $urandom, 0, 1'b1, 1'b0);
      // more items than the count
      add_op(ACT_PUSH, 32'h1234_5678, 2, 1'b0, 1'b0);
      add_op(ACT_PUSH, 32'h8765_4321, 5, 1'b0, 1'b0);
      add_op(ACT_PUSH, 32'hDEAD_BEEF, 1, 1'b0, 1'b0);
      add_op(ACT_PUSH, 32'h5A5A_5A5A, 0, 1'b1, 1'b0);
      // fewer items than the count
      add_op(ACT_PUSH, 32'hCAFE_F00D, 3, 1'b1, 1'b1);
      add_op(ACT_POP, $urandom, 2, 1'b0, 1'b1);
      // over the free space
      add_op(ACT_PUSH, $urandom, 64, 1'b0, 1'b0);
      add_op(ACT_PUSH, $urandom, 3, 1'b1, 1'b0);
      // pop while a batch is open
      add_op(ACT_PUSH, 32'h0F0F_0F0F, 2, 1'b0, 1'b0);
      add_op(ACT_POP, $urandom, 4, 1'b1, 1'b0);
      add_op(ACT_PUSH, 32'hF0F0_F0F0, 7, 1'b1, 1'b0);
      add_op(ACT_POP, $urandom, 64, 1'b0, 1'b0);
      add_op(ACT_POP, $urandom, 2, 1'b1, 1'b0);
      // clear abandons an open batch
      add_op(ACT_PUSH, $urandom, 1, 1'b0, 1'b0);
      add_op(ACT_CLEAR, $urandom, 64, 1'b1, 1'b1);
      add_op(ACT_QUERY, $urandom, 64, 1'b1, 1'b0);

      // random batches, pops, queries and clears
      track_fill = 0;
      while (op_backlog.size() < 465) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            k = $urandom_range(0, 99);
            if (k < 5) begin
               c = 0;
            end else if (k < 12) begin
               c = DEPTH - track_fill;
            end else if (k < 27) begin
               c = $urandom_range(9, 64);
            end else begin
               c = $urandom_range(1, 8);
            end
            k = $urandom_range(0, 9);
            if (c == 0) begin
               n = $urandom_range(1, 2);
            end else if (k == 0) begin
               n = $urandom_range(1, c);
            end else if (k == 1) begin
               n = c + $urandom_range(1, 3);
            end else begin
               n = c;
            end
            fits = (c <= DEPTH - track_fill);
            for (int i = 0; i < n; i++) begin
               add_op(ACT_PUSH, $urandom, (i == 0) ? c : $urandom_range(0, 64),
                      (i == n - 1), 1'($urandom_range(0, 1)));
               if (i == 0 && n > 1 && $urandom_range(0, 9) == 0) begin
                  if (track_fill > 0 && $urandom_range(0, 1) == 1) begin
                     k = $urandom_range(1, track_fill);
                     add_op(ACT_POP, $urandom, k, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
                     track_fill -= k;
                  end else begin
                     add_op(ACT_QUERY, $urandom, $urandom_range(0, 64),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  end
               end
            end
            if (fits) begin
               track_fill += (n < c) ? n : c;
            end
         end else if (r < 80) begin
            if (track_fill > 0 && $urandom_range(0, 99) < 80) begin
               c = $urandom_range(1, track_fill);
            end else begin
               c = $urandom_range(0, 64);
            end
            add_op(ACT_POP, $urandom, c, 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 3) == 0));
            if (c > 0 && c <= track_fill) begin
               track_fill -= c;
            end
         end else if (r < 88) begin
            add_op(ACT_QUERY, $urandom, $urandom_range(0, 64), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
         end else if (r < 92) begin
            add_op(ACT_CLEAR, $urandom, $urandom_range(0, 64), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
            track_fill = 0;
         end else begin
            // stray single-item batch or stray pop
            c = $urandom_range(0, 64);
            if ($urandom_range(0, 1) == 1) begin
               add_op(ACT_PUSH, $urandom, c, 1'b1, 1'($urandom_range(0, 1)));
               if (c <= DEPTH - track_fill && c > 0) begin
                  track_fill += 1;
               end
            end else begin
               add_op(ACT_POP, $urandom, c, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
               if (c > 0 && c <= track_fill) begin
                  track_fill -= c;
               end
            end
         end
      end
      add_op(ACT_QUERY, $urandom, 0, 1'b1, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() > 0 || req_tvalid || due_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
